// File: sv/fpkc_pkg.sv
// shared widths, codes, constants and handshake types of the keypad calculator
package fpkc_pkg;

	localparam int CMD_W   = 3;
	localparam int DIGIT_W = 4;
	localparam int OPC_W   = 2;
	localparam int FX_W    = 32;
	localparam int TYPED_W = 50;
	localparam int CNT_W   = 4;
	localparam int PEND_W  = 3;
	localparam int PROD_W  = 2 * FX_W;

	// key commands
	localparam logic [CMD_W-1:0] CMD_DIGIT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_OPERATOR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EQUALS   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BKSP     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

	// pending operator codes
	localparam logic [PEND_W-1:0] PEND_NONE = 3'd0;
	localparam logic [PEND_W-1:0] PEND_ADD  = 3'd1;
	localparam logic [PEND_W-1:0] PEND_SUB  = 3'd2;
	localparam logic [PEND_W-1:0] PEND_MUL  = 3'd3;
	localparam logic [PEND_W-1:0] PEND_DIV  = 3'd4;

	localparam logic [CNT_W-1:0]   MAX_DIGITS = 4'd15;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
	localparam logic [FX_W-1:0]    FX_SCALE   = 32'd10000;
	localparam logic [FX_W-1:0]    DEC_BASE   = 32'd10;

	// serial arithmetic step counts
	localparam int MUL_STEPS = FX_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic            go;
		logic [FX_W-1:0] a;
		logic [FX_W-1:0] b;
	} fpkc_mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] p;
	} fpkc_mul_rsp_t;

	typedef struct packed {
		logic              go;
		logic [PROD_W-1:0] n;
		logic [FX_W-1:0]   d;
	} fpkc_div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] q;
	} fpkc_div_rsp_t;

endpackage

// File: sv/fpkc_ifs.sv
// key and result channel interfaces
interface fpkc_key_if;
	logic                           valid;
	logic                           ready;
	logic [fpkc_pkg::CMD_W-1:0]     command;
	logic [fpkc_pkg::DIGIT_W-1:0]   digit;
	logic [fpkc_pkg::OPC_W-1:0]     operator_code;

	modport source (output valid, output command, output digit, output operator_code,
		input ready);
	modport sink (input valid, input command, input digit, input operator_code,
		output ready);
endinterface

interface fpkc_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [fpkc_pkg::FX_W-1:0]   display_fixed;
	logic [fpkc_pkg::TYPED_W-1:0]       typed_value;
	logic                               typing;
	logic [fpkc_pkg::CNT_W-1:0]         digit_count;
	logic                               error_shown;
	logic [fpkc_pkg::PEND_W-1:0]        pending_operator;

	modport source (output valid, output display_fixed, output typed_value, output typing,
		output digit_count, output error_shown, output pending_operator, input ready);
	modport sink (input valid, input display_fixed, input typed_value, input typing,
		input digit_count, input error_shown, input pending_operator, output ready);
endinterface

// File: sv/fpkc_mul.sv
// bit-serial unsigned 32x32 shift-add multiplier
module fpkc_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fpkc_pkg::fpkc_mul_req_t req,
	output fpkc_pkg::fpkc_mul_rsp_t rsp
);
	import fpkc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [FX_W-1:0]      a_q;
	logic [PROD_W-1:0]    p_q;
	logic [FX_W:0]        sum;

	// add multiplicand into the upper half when the current multiplier bit is set
	assign sum = {1'b0, p_q[PROD_W-1:FX_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			p_q <= {{FX_W{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[FX_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;
endmodule

// File: sv/fpkc_div.sv
// bit-serial restoring divider, 64-bit dividend by 32-bit divisor
module fpkc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fpkc_pkg::fpkc_div_req_t req,
	output fpkc_pkg::fpkc_div_rsp_t rsp
);
	import fpkc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    n_q;
	logic [FX_W-1:0]      d_q;
	logic [FX_W-1:0]      r_q;
	logic [FX_W:0]        shifted;
	logic [FX_W:0]        diff;
	logic                 ge;

	// one quotient bit per cycle
	assign shifted = {r_q, n_q[PROD_W-1]};
	assign ge      = shifted >= {1'b0, d_q};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			n_q <= req.n;
			d_q <= req.d;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[PROD_W-2:0], ge};
			r_q <= ge ? diff[FX_W-1:0] : shifted[FX_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = n_q;
endmodule

// File: sv/fixed_point_keypad_calculator.sv
// keypad calculator top level: key sequencer, state registers and result register
//
//  channel | dir | payload                                                    | handshake
//  key     | in  | command, digit, operator_code                              | valid/ready
//  res     | out | display_fixed, typed_value, typing, digit_count,           | valid/ready
//          |     | error_shown, pending_operator                              |
//
// one key is in work at a time; key.ready is high only while the sequencer is idle
// operator, add, subtract, divide by zero, clear and ignored keys go straight to the finishing step
// digit: the display is formed by the 32-step serial multiply
// multiply, divide: 32 multiply then 64 divide steps; backspace: divide then multiply, last digit divide only
// arst_n clears all calculator state to zero, no operator pending, no number open
// a held result stalls only the finishing step; the next key is taken once it leaves
module fixed_point_keypad_calculator (
	input  logic        clk,
	input  logic        arst_n,
	fpkc_key_if.sink    key,
	fpkc_res_if.source  res
);
	import fpkc_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// what the serial units are working on
	localparam logic [1:0] JOB_DISP = 2'd0;
	localparam logic [1:0] JOB_MULT = 2'd1;
	localparam logic [1:0] JOB_DIVI = 2'd2;
	localparam logic [1:0] JOB_BKSP = 2'd3;

	logic [1:0]         st_q;
	logic [1:0]         job_q;
	logic               neg_q;
	logic [FX_W-1:0]    absb_q;

	// calculator state
	logic [TYPED_W-1:0] typed_q;
	logic [CNT_W-1:0]   digits_q;
	logic               entry_q;
	logic [FX_W-1:0]    shown_q;
	logic               err_q;
	logic [FX_W-1:0]    first_q;
	logic [PEND_W-1:0]  pend_q;
	// equal to the displayed value of the current state once the work of a key is done
	logic [FX_W-1:0]    disp_q;

	// result register
	logic               res_valid_q;
	logic [FX_W-1:0]    res_disp_q;
	logic [TYPED_W-1:0] res_typed_q;
	logic               res_typing_q;
	logic [CNT_W-1:0]   res_count_q;
	logic               res_err_q;
	logic [PEND_W-1:0]  res_pend_q;

	fpkc_mul_req_t      mul_req;
	fpkc_mul_rsp_t      mul_rsp;
	fpkc_div_req_t      div_req;
	fpkc_div_rsp_t      div_rsp;

	logic               key_fire;
	logic               out_free;
	logic [TYPED_W-1:0] typed_app;
	logic [FX_W-1:0]    abs_a;
	logic [FX_W-1:0]    abs_b;
	logic [FX_W-1:0]    sum_ab;
	logic [FX_W-1:0]    dif_ab;
	logic [FX_W-1:0]    q_signed;
	logic               digit_ok;

	assign key.ready = (st_q == ST_IDLE);
	assign key_fire  = key.valid && key.ready;
	assign out_free  = !res_valid_q || res.ready;

	// typed*10 + digit
	assign typed_app = {typed_q[TYPED_W-4:0], 3'b000} + {typed_q[TYPED_W-2:0], 1'b0}
		+ TYPED_W'(key.digit);
	assign digit_ok  = key.digit <= DIGIT_MAX;

	// magnitudes of the two operands for the signed multiply and divide
	assign abs_a    = first_q[FX_W-1] ? (FX_W'(0) - first_q) : first_q;
	assign abs_b    = disp_q[FX_W-1] ? (FX_W'(0) - disp_q) : disp_q;
	assign sum_ab   = first_q + disp_q;
	assign dif_ab   = first_q - disp_q;
	// quotient truncated toward zero, sign put back, low word kept
	assign q_signed = neg_q ? (FX_W'(0) - div_rsp.q[FX_W-1:0]) : div_rsp.q[FX_W-1:0];

	// start requests for the serial units
	always_comb begin
		mul_req = '0;
		div_req = '0;
		priority if (st_q == ST_IDLE && key_fire) begin
			unique case (key.command)
				CMD_DIGIT: begin
					if (digit_ok && !entry_q) begin
						mul_req.go = 1'b1;
						mul_req.a  = FX_W'(key.digit);
						mul_req.b  = FX_SCALE;
					end else if (digit_ok && digits_q < MAX_DIGITS) begin
						mul_req.go = 1'b1;
						mul_req.a  = typed_app[FX_W-1:0];
						mul_req.b  = FX_SCALE;
					end
				end
				CMD_EQUALS: begin
					if (pend_q == PEND_MUL) begin
						mul_req.go = 1'b1;
						mul_req.a  = abs_a;
						mul_req.b  = abs_b;
					end else if (pend_q == PEND_DIV && disp_q != '0) begin
						mul_req.go = 1'b1;
						mul_req.a  = abs_a;
						mul_req.b  = FX_SCALE;
					end
				end
				CMD_BKSP: begin
					if (entry_q) begin
						div_req.go = 1'b1;
						div_req.n  = PROD_W'(typed_q);
						div_req.d  = DEC_BASE;
					end
				end
				default: ;
			endcase
		end else if (st_q == ST_MUL && mul_rsp.done && job_q != JOB_DISP) begin
			div_req.go = 1'b1;
			div_req.n  = mul_rsp.p;
			div_req.d  = (job_q == JOB_MULT) ? FX_SCALE : absb_q;
		end else if (st_q == ST_DIV && div_rsp.done && job_q == JOB_BKSP
			&& digits_q != CNT_W'(1)) begin
			mul_req.go = 1'b1;
			mul_req.a  = div_rsp.q[FX_W-1:0];
			mul_req.b  = FX_SCALE;
		end else begin
			mul_req = '0;
		end
	end

	fpkc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	fpkc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// key sequencer and calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			job_q    <= JOB_DISP;
			neg_q    <= 1'b0;
			absb_q   <= '0;
			typed_q  <= '0;
			digits_q <= '0;
			entry_q  <= 1'b0;
			shown_q  <= '0;
			err_q    <= 1'b0;
			first_q  <= '0;
			pend_q   <= PEND_NONE;
			disp_q   <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (key_fire) begin
						st_q <= ST_OUT;
						unique case (key.command)
							CMD_DIGIT: begin
								if (digit_ok && !entry_q) begin
									// a new number starts
									typed_q  <= TYPED_W'(key.digit);
									digits_q <= CNT_W'(1);
									entry_q  <= 1'b1;
									err_q    <= 1'b0;
									job_q    <= JOB_DISP;
									st_q     <= ST_MUL;
								end else if (digit_ok && digits_q < MAX_DIGITS) begin
									typed_q  <= typed_app;
									digits_q <= digits_q + 1'b1;
									job_q    <= JOB_DISP;
									st_q     <= ST_MUL;
								end
							end
							CMD_OPERATOR: begin
								first_q <= disp_q;
								shown_q <= disp_q;
								pend_q  <= PEND_W'(key.operator_code) + PEND_W'(1);
								entry_q <= 1'b0;
							end
							CMD_EQUALS: begin
								if (pend_q != PEND_NONE) begin
									entry_q <= 1'b0;
									pend_q  <= PEND_NONE;
									err_q   <= 1'b0;
									neg_q   <= first_q[FX_W-1] ^ disp_q[FX_W-1];
									absb_q  <= abs_b;
									unique case (pend_q)
										PEND_ADD: begin
											shown_q <= sum_ab;
											disp_q  <= sum_ab;
										end
										PEND_SUB: begin
											shown_q <= dif_ab;
											disp_q  <= dif_ab;
										end
										PEND_MUL: begin
											job_q <= JOB_MULT;
											st_q  <= ST_MUL;
										end
										default: begin
											if (disp_q == '0) begin
												// division by zero
												shown_q <= '0;
												disp_q  <= '0;
												err_q   <= 1'b1;
											end else begin
												job_q <= JOB_DIVI;
												st_q  <= ST_MUL;
											end
										end
									endcase
								end
							end
							CMD_BKSP: begin
								if (entry_q) begin
									job_q <= JOB_BKSP;
									st_q  <= ST_DIV;
								end
							end
							CMD_CLEAR: begin
								typed_q  <= '0;
								digits_q <= '0;
								entry_q  <= 1'b0;
								shown_q  <= '0;
								err_q    <= 1'b0;
								first_q  <= '0;
								pend_q   <= PEND_NONE;
								disp_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					if (mul_rsp.done) begin
						if (job_q == JOB_DISP) begin
							disp_q <= err_q ? '0 : mul_rsp.p[FX_W-1:0];
							st_q   <= ST_OUT;
						end else begin
							st_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (job_q == JOB_BKSP) begin
							if (digits_q == CNT_W'(1)) begin
								// last digit gone, display returns to zero
								typed_q  <= '0;
								digits_q <= '0;
								shown_q  <= '0;
								entry_q  <= 1'b0;
								disp_q   <= '0;
								st_q     <= ST_OUT;
							end else begin
								typed_q  <= div_rsp.q[TYPED_W-1:0];
								digits_q <= digits_q - 1'b1;
								job_q    <= JOB_DISP;
								st_q     <= ST_MUL;
							end
						end else begin
							shown_q <= q_signed;
							disp_q  <= q_signed;
							st_q    <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free) begin
			res_disp_q   <= disp_q;
			res_typed_q  <= entry_q ? typed_q : '0;
			res_typing_q <= entry_q;
			res_count_q  <= entry_q ? digits_q : '0;
			res_err_q    <= err_q;
			res_pend_q   <= pend_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.display_fixed    = res_disp_q;
	assign res.typed_value      = res_typed_q;
	assign res.typing           = res_typing_q;
	assign res.digit_count      = res_count_q;
	assign res.error_shown      = res_err_q;
	assign res.pending_operator = res_pend_q;

	// an open number never carries the error mark
	a_entry_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q |-> !err_q)
		else $error("open number with error mark set");

	// an open number holds between one and the maximum count of digits
	a_entry_digits: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q |-> (digits_q != '0 && digits_q <= MAX_DIGITS))
		else $error("digit count out of range while typing");

	// serial unit completions only arrive where the sequencer waits for them
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> st_q == ST_MUL)
		else $error("multiply finished outside its wait state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> st_q == ST_DIV)
		else $error("divide finished outside its wait state");

	// an accepted key always leads to a result before the next key
	a_key_to_work: assert property (@(posedge clk) disable iff (!arst_n)
		key_fire |=> st_q != ST_IDLE)
		else $error("accepted key skipped the result step");
endmodule
